// ===== rtl/lafd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lafd_pkg;

	// Default geometry of the managed region.
	localparam int DEF_STACK_BYTES  = 4096;
	localparam int DEF_ALIGN_BYTES  = 8;
	localparam int DEF_HEADER_BYTES = 16;

	// Fixed widths of the transaction fields.
	localparam int REQ_W = 16;
	localparam int OFS_W = 12;

	// Width of the shared divider operand (rounded request fits here).
	localparam int DIV_W = REQ_W + 1;

	// Request kinds.
	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CALC,
		ST_ALLOC,
		ST_FDEC,
		ST_MARK,
		ST_WALK
	} state_t;

endpackage

`default_nettype wire

// ===== rtl/lafd_hdr_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lafd_hdr_ram #(
	parameter int DEPTH  = 512,
	parameter int ADDR_W = 9,
	parameter int DATA_W = 24
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	// Single write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Single read port with registered data.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/lafd_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lafd_div #(
	parameter int DIVISOR = 8,
	parameter int IN_W    = 17
) (
	input  wire logic            clk,
	input  wire logic [IN_W-1:0] x,
	output logic      [IN_W-1:0] q_s1
);

	// Reciprocal scaled so that the truncated product is exact over the input range.
	localparam int SHIFT  = IN_W + 5;
	localparam int PROD_W = IN_W + SHIFT + 1;
	localparam logic [SHIFT:0] RECIP = (SHIFT+1)'((2**SHIFT + DIVISOR - 1) / DIVISOR);

	logic [PROD_W-1:0] prod;

	// Multiply by the reciprocal.
	always_comb begin
		prod = PROD_W'(x) * PROD_W'(RECIP);
	end

	// Register the quotient.
	always_ff @(posedge clk) begin
		q_s1 <= prod[SHIFT+IN_W-1:SHIFT];
	end

endmodule

`default_nettype wire

// ===== rtl/lifo_allocator_deferred_free.sv =====
// Sequence: an allocate passes CALC and ALLOC before the done strobe; a free passes CALC
// and FDEC and ends there when the offset is ignored, goes on to MARK when a lower chunk
// is marked, or stays in WALK while popping headers (one header-memory read per cycle).
// Throughput: one transaction at a time; busy is high until the done strobe appears.
// Reset: arst_n clears the stack to empty; the header memory is not cleared.
// Results are shown for one cycle on done; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module lifo_allocator_deferred_free
	import lafd_pkg::*;
#(
	parameter int STACK_BYTES  = DEF_STACK_BYTES,
	parameter int ALIGN_BYTES  = DEF_ALIGN_BYTES,
	parameter int HEADER_BYTES = DEF_HEADER_BYTES
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire logic             kind,
	input  wire logic [REQ_W-1:0] request_size,
	input  wire logic [OFS_W-1:0] release_offset,
	output logic                  done,
	output logic      [OFS_W-1:0] data_offset,
	output logic                  failed
);

	localparam int SLOT_COUNT  = STACK_BYTES / ALIGN_BYTES;
	localparam int SLOT_W      = $clog2(SLOT_COUNT);
	localparam int SIZE_W      = $clog2(SLOT_COUNT + 1);
	localparam int HDR_UNITS   = (HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES;
	localparam int HDR_SPAN    = HDR_UNITS * ALIGN_BYTES;
	localparam int LIMIT_UNITS = (STACK_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES;
	localparam int ENTRY_W     = SLOT_W + 1 + SIZE_W + 1;
	localparam int SUM_W       = DIV_W + 1;
	localparam int OFSP_W      = SUM_W + 5;
	localparam int REMP_W      = DIV_W + 5;

	state_t state_q, state_d;

	logic             kind_q;
	logic [REQ_W-1:0] req_q;
	logic [OFS_W-1:0] off_q;

	logic [SLOT_W-1:0] top_slot_q;
	logic              top_valid_q;
	logic [SIZE_W-1:0] top_size_q;
	logic [SLOT_W-1:0] slot_q;
	logic              first_q;
	logic [SIZE_W-1:0] steps_q;

	logic             done_q;
	logic [OFS_W-1:0] data_offset_q;
	logic             failed_q;

	logic [DIV_W-1:0] div_x;
	logic [DIV_W-1:0] quot;

	logic               mem_we;
	logic [SLOT_W-1:0]  mem_waddr;
	logic [ENTRY_W-1:0] mem_wdata;
	logic               mem_re;
	logic [SLOT_W-1:0]  mem_raddr;
	logic [ENTRY_W-1:0] mem_rdata;

	logic [SLOT_W-1:0] r_prev_slot;
	logic              r_prev_valid;
	logic [SIZE_W-1:0] r_size;
	logic              r_free;

	logic [SUM_W-1:0]  base_units;
	logic [SUM_W-1:0]  start_units;
	logic [SUM_W-1:0]  end_units;
	logic [OFSP_W-1:0] ofs_full;
	logic              fit;

	logic [OFS_W-1:0]  hdr_ofs;
	logic [REMP_W-1:0] rem_back;
	logic              free_valid;
	logic              is_top;
	logic [SLOT_W-1:0] quot_slot;

	logic walk_go;
	logic walk_pop;

	logic             emit;
	logic [OFS_W-1:0] emit_ofs;
	logic             emit_fail;

	// Shared constant divider: rounds the request up, or maps a header offset to its slot.
	always_comb begin
		hdr_ofs = off_q - OFS_W'(HDR_SPAN);
		if (kind_q == KIND_FREE) begin
			div_x = DIV_W'(hdr_ofs);
		end else begin
			div_x = DIV_W'(req_q) + DIV_W'(ALIGN_BYTES - 1);
		end
	end

	lafd_div #(
		.DIVISOR(ALIGN_BYTES),
		.IN_W   (DIV_W)
	) u_div (
		.clk (clk),
		.x   (div_x),
		.q_s1(quot)
	);

	lafd_hdr_ram #(
		.DEPTH (SLOT_COUNT),
		.ADDR_W(SLOT_W),
		.DATA_W(ENTRY_W)
	) u_hdr_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// Header entry layout: previous slot, previous valid, size in slots, free mark.
	always_comb begin
		r_prev_slot  = mem_rdata[ENTRY_W-1 -: SLOT_W];
		r_prev_valid = mem_rdata[SIZE_W+1];
		r_size       = mem_rdata[SIZE_W:1];
		r_free       = mem_rdata[0];
	end

	// Placement of a new chunk and the fit check.
	always_comb begin
		if (top_valid_q) begin
			base_units = SUM_W'(top_slot_q) + SUM_W'(HDR_UNITS) + SUM_W'(top_size_q);
		end else begin
			base_units = '0;
		end
		start_units = base_units + SUM_W'(HDR_UNITS);
		end_units   = start_units + SUM_W'(quot);
		fit         = end_units < SUM_W'(LIMIT_UNITS);
		ofs_full    = OFSP_W'(start_units) * OFSP_W'(ALIGN_BYTES);
	end

	// Validation of a release offset.
	always_comb begin
		quot_slot  = quot[SLOT_W-1:0];
		rem_back   = REMP_W'(quot) * REMP_W'(ALIGN_BYTES);
		free_valid = (off_q >= OFS_W'(HDR_SPAN)) && (rem_back == REMP_W'(hdr_ofs))
			&& (quot < DIV_W'(SLOT_COUNT));
		is_top     = top_valid_q && (quot_slot == top_slot_q);
	end

	// Pop walk: the first header is always popped, later ones only while marked free.
	always_comb begin
		walk_go  = first_q || (r_free && (steps_q < SIZE_W'(SLOT_COUNT)));
		walk_pop = walk_go && r_prev_valid;
	end

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_CALC;
				end
			end
			ST_CALC: begin
				state_d = (kind_q == KIND_FREE) ? ST_FDEC : ST_ALLOC;
			end
			ST_ALLOC: begin
				state_d = ST_IDLE;
			end
			ST_FDEC: begin
				if (!free_valid) begin
					state_d = ST_IDLE;
				end else if (is_top) begin
					state_d = ST_WALK;
				end else begin
					state_d = ST_MARK;
				end
			end
			ST_MARK: begin
				state_d = ST_IDLE;
			end
			ST_WALK: begin
				state_d = walk_pop ? ST_WALK : ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Output and memory control logic.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = base_units[SLOT_W-1:0];
		mem_wdata = {top_slot_q, top_valid_q, quot[SIZE_W-1:0], 1'b0};
		mem_re    = 1'b0;
		mem_raddr = top_slot_q;
		emit      = 1'b0;
		emit_ofs  = '0;
		emit_fail = 1'b0;
		case (state_q)
			ST_ALLOC: begin
				mem_we    = fit;
				emit      = 1'b1;
				emit_ofs  = fit ? ofs_full[OFS_W-1:0] : '0;
				emit_fail = !fit;
			end
			ST_FDEC: begin
				if (!free_valid) begin
					emit = 1'b1;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = is_top ? top_slot_q : quot_slot;
				end
			end
			ST_MARK: begin
				mem_we    = 1'b1;
				mem_waddr = slot_q;
				mem_wdata = {mem_rdata[ENTRY_W-1:1], 1'b1};
				emit      = 1'b1;
			end
			ST_WALK: begin
				mem_re    = walk_pop;
				mem_raddr = r_prev_slot;
				emit      = !walk_pop;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// State register and stack pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			top_slot_q  <= '0;
			top_valid_q <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= emit;
			if (state_q == ST_ALLOC && fit) begin
				top_slot_q  <= base_units[SLOT_W-1:0];
				top_valid_q <= 1'b1;
			end
			if (state_q == ST_WALK && walk_go) begin
				if (r_prev_valid) begin
					top_slot_q <= r_prev_slot;
				end else begin
					top_slot_q  <= '0;
					top_valid_q <= 1'b0;
				end
			end
		end
	end

	// Transaction payload, walk bookkeeping and result registers.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			kind_q <= kind;
			req_q  <= request_size;
			off_q  <= release_offset;
		end
		if (state_q == ST_ALLOC && fit) begin
			top_size_q <= quot[SIZE_W-1:0];
		end
		if (state_q == ST_FDEC) begin
			slot_q  <= quot_slot;
			first_q <= 1'b1;
			steps_q <= '0;
		end
		if (state_q == ST_WALK) begin
			if (!first_q) begin
				top_size_q <= r_size;
			end
			if (walk_pop) begin
				first_q <= 1'b0;
				steps_q <= steps_q + SIZE_W'(1);
			end
		end
		if (emit) begin
			data_offset_q <= emit_ofs;
			failed_q      <= emit_fail;
		end
	end

	assign busy        = (state_q != ST_IDLE);
	assign done        = done_q;
	assign data_offset = data_offset_q;
	assign failed      = failed_q;

endmodule

`default_nettype wire

// ===== tb/lifo_allocator_deferred_free_test.sv =====
`timescale 1ns / 1ps

module lifo_allocator_deferred_free_test;
	import lafd_pkg::*;

	localparam int ALIGN  = DEF_ALIGN_BYTES;
	localparam int SPAN   = ((DEF_HEADER_BYTES + ALIGN - 1) / ALIGN) * ALIGN;
	localparam int SLOTS  = DEF_STACK_BYTES / ALIGN;
	localparam int SLOT_W = $clog2(SLOTS);

	// How the driver picks the release offset of a free once it is presented.
	typedef enum int {
		PLAN_ALLOC,
		PLAN_FREE_TOP,
		PLAN_FREE_LIVE,
		PLAN_FREE_STALE,
		PLAN_FREE_NULL,
		PLAN_FREE_JUNK,
		PLAN_FREE_AT
	} plan_op_t;

	typedef struct {
		plan_op_t         op;
		logic [REQ_W-1:0] size;
		int unsigned      pick;
	} plan_t;

	typedef struct packed {
		logic [OFS_W-1:0] ofs;
		logic             fail;
	} reply_t;

	logic             clk;
	logic             arst_n         = 1'b0;
	logic             start          = 1'b0;
	logic             kind           = KIND_ALLOC;
	logic [REQ_W-1:0] request_size   = '0;
	logic [OFS_W-1:0] release_offset = '0;
	logic             busy;
	logic             done;
	logic [OFS_W-1:0] data_offset;
	logic             failed;

	lifo_allocator_deferred_free i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.kind           (kind),
		.request_size   (request_size),
		.release_offset (release_offset),
		.done           (done),
		.data_offset    (data_offset),
		.failed         (failed)
	);

	// Predicted allocator state: one header per slot plus the top pointer.
	logic [SLOT_W-1:0] hdr_prev    [SLOTS] = '{default: '0};
	bit                hdr_prev_ok [SLOTS] = '{default: 1'b0};
	logic [OFS_W-1:0]  hdr_len     [SLOTS] = '{default: '0};
	bit                hdr_freed   [SLOTS] = '{default: 1'b0};
	bit                hdr_seen    [SLOTS] = '{default: 1'b0};
	logic [SLOT_W-1:0] top_slot = '0;
	bit                top_ok   = 1'b0;

	plan_t  request_plan[$];
	reply_t pending_replies[$];
	int     accepted_cnt = 0;
	int     err_cnt      = 0;
	bit     taken        = 1'b0;
	int     burst_left   = 0;
	int     gap_left     = 0;
	bit     drain_hold   = 1'b0;

	function automatic logic [OFS_W-1:0] slot_to_ofs(logic [SLOT_W-1:0] s);
		return OFS_W'(int'(s) * ALIGN + SPAN);
	endfunction

	// Applies one transaction to the predicted state and returns its result.
	function automatic reply_t stack_step(logic k, logic [REQ_W-1:0] req,
			logic [OFS_W-1:0] ofs);
		reply_t            r;
		int unsigned       chunk;
		int unsigned       base;
		int unsigned       steps;
		logic [SLOT_W-1:0] s;
		bit                walking;
		r.ofs = '0;
		r.fail = 1'b0;
		if (k == KIND_ALLOC) begin
			chunk = ((int'(req) + ALIGN - 1) / ALIGN) * ALIGN;
			base = 0;
			if (top_ok) begin
				base = top_slot * ALIGN + SPAN + hdr_len[top_slot];
			end
			// Header plus chunk must end strictly below the region end.
			if (base + SPAN + chunk >= DEF_STACK_BYTES) begin
				r.fail = 1'b1;
			end else begin
				s = SLOT_W'(base / ALIGN);
				hdr_prev[s] = top_slot;
				hdr_prev_ok[s] = top_ok;
				hdr_len[s] = OFS_W'(chunk);
				hdr_freed[s] = 1'b0;
				hdr_seen[s] = 1'b1;
				top_slot = s;
				top_ok = 1'b1;
				r.ofs = OFS_W'(base + SPAN);
			end
		end else if (ofs >= SPAN && ((ofs - SPAN) % ALIGN) == 0
				&& (ofs - SPAN) / ALIGN < SLOTS) begin
			s = SLOT_W'((ofs - SPAN) / ALIGN);
			if (top_ok && s == top_slot) begin
				// Pop the top, then keep popping chunks already marked free.
				steps = 0;
				walking = 1'b1;
				while (walking) begin
					if (!hdr_prev_ok[top_slot]) begin
						top_ok = 1'b0;
						top_slot = '0;
						walking = 1'b0;
					end else begin
						top_slot = hdr_prev[top_slot];
						steps++;
						walking = hdr_freed[top_slot] && steps < SLOTS;
					end
				end
			end else begin
				hdr_freed[s] = 1'b1;
			end
		end
		return r;
	endfunction

	// Turns a planned free into an offset that never reads an unwritten header.
	function automatic logic [OFS_W-1:0] release_for(plan_t p);
		logic [SLOT_W-1:0] s;
		logic [OFS_W-1:0]  raw;
		int                depth;
		case (p.op)
			PLAN_FREE_TOP: begin
				if (top_ok) return slot_to_ofs(top_slot);
			end
			PLAN_FREE_LIVE: begin
				if (top_ok) begin
					depth = 1;
					s = top_slot;
					while (hdr_prev_ok[s] && depth < SLOTS) begin
						s = hdr_prev[s];
						depth++;
					end
					s = top_slot;
					repeat (p.pick % depth) s = hdr_prev[s];
					return slot_to_ofs(s);
				end
			end
			PLAN_FREE_NULL: return '0;
			PLAN_FREE_AT: return p.pick[OFS_W-1:0];
			PLAN_FREE_JUNK: begin
				raw = p.pick[OFS_W-1:0];
				// An aligned offset over a never-written slot is pushed off the slot grid.
				if (raw >= SPAN && ((raw - SPAN) % ALIGN) == 0
						&& !hdr_seen[(raw - SPAN) / ALIGN]) begin
					raw[0] = 1'b1;
				end
				return raw;
			end
			default: ;
		endcase
		// A header written at some point, live or not; also used on an empty stack.
		for (int i = 0; i < SLOTS; i++) begin
			s = SLOT_W'((p.pick + i) % SLOTS);
			if (hdr_seen[s]) return slot_to_ofs(s);
		end
		return '0;
	endfunction

	function automatic logic [REQ_W-1:0] draw_size();
		int roll;
		roll = $urandom_range(99);
		if (roll < 50) return REQ_W'($urandom_range(40));
		if (roll < 80) return REQ_W'($urandom_range(400, 41));
		if (roll < 95) return REQ_W'($urandom_range(4095, 401));
		return REQ_W'($urandom);
	endfunction

	task automatic plan_add(plan_op_t op, logic [REQ_W-1:0] size, int unsigned pick);
		plan_t p;
		p.op = op;
		p.size = size;
		p.pick = pick;
		request_plan.push_back(p);
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Driver: presents planned transactions in bursts separated by idle gaps.
	always @(negedge clk) begin : driver
		plan_t p;
		if (arst_n && !(start && !taken)) begin
			if (start) begin
				if (burst_left > 0) burst_left--;
				if (accepted_cnt % 200 == 0) drain_hold = 1'b1;
			end
			if (burst_left == 0) begin
				if ($urandom_range(4) == 0) begin
					burst_left = $urandom_range(80, 40);
					gap_left = 0;
				end else begin
					burst_left = $urandom_range(20, 1);
					gap_left = $urandom_range(15);
				end
			end
			if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (drain_hold && pending_replies.size() != 0) begin
				start <= 1'b0;
			end else if (request_plan.size() != 0) begin
				drain_hold = 1'b0;
				p = request_plan.pop_front();
				if (p.op == PLAN_ALLOC) begin
					kind <= KIND_ALLOC;
					request_size <= p.size;
					release_offset <= OFS_W'($urandom);
				end else begin
					kind <= KIND_FREE;
					request_size <= REQ_W'($urandom);
					release_offset <= release_for(p);
				end
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: checks each result and predicts each accepted transaction.
	always @(posedge clk) begin : monitor
		reply_t want;
		if (arst_n) begin
			if (done) begin
				if (pending_replies.size() == 0) begin
					$display("%0t: result with nothing expected: data_offset %0d failed %0d",
						$time, data_offset, failed);
					err_cnt++;
				end else begin
					want = pending_replies.pop_front();
					if (data_offset !== want.ofs) begin
						$display("%0t: data_offset expected %0d, actual %0d",
							$time, want.ofs, data_offset);
						err_cnt++;
					end
					if (failed !== want.fail) begin
						$display("%0t: failed expected %0d, actual %0d",
							$time, want.fail, failed);
						err_cnt++;
					end
				end
			end
			if (start && !busy) begin
				pending_replies.push_back(stack_step(kind, request_size, release_offset));
				accepted_cnt++;
			end
		end
		taken <= arst_n && start && !busy;
	end

	initial begin
		int       total;
		int       alloc_pct;
		int       roll;
		plan_op_t op;
		alloc_pct = 50;

		// Directed: size extremes, rounding, null and off-grid frees, deferred pops.
		plan_add(PLAN_ALLOC, 16'd0, 0);
		plan_add(PLAN_ALLOC, 16'd1, 0);
		plan_add(PLAN_ALLOC, 16'hFFFF, 0);
		plan_add(PLAN_FREE_NULL, 16'hFFFF, 0);
		plan_add(PLAN_FREE_AT, 16'd0, 8);
		plan_add(PLAN_FREE_AT, 16'd0, 4095);
		plan_add(PLAN_ALLOC, 16'd100, 0);
		plan_add(PLAN_ALLOC, 16'd8, 0);
		plan_add(PLAN_ALLOC, 16'd24, 0);
		plan_add(PLAN_FREE_LIVE, 16'd0, 2);
		plan_add(PLAN_FREE_LIVE, 16'd0, 1);
		plan_add(PLAN_FREE_TOP, 16'd0, 0);
		plan_add(PLAN_FREE_TOP, 16'd0, 0);
		plan_add(PLAN_FREE_TOP, 16'd0, 0);
		// Mark on an empty stack, then the exact fit and the first size that misses.
		plan_add(PLAN_FREE_STALE, 16'd0, 0);
		plan_add(PLAN_ALLOC, 16'd4072, 0);
		plan_add(PLAN_ALLOC, 16'd0, 0);
		plan_add(PLAN_FREE_TOP, 16'd0, 0);
		plan_add(PLAN_ALLOC, 16'd4073, 0);
		// Pop walk that runs down to the bottom chunk.
		plan_add(PLAN_ALLOC, 16'd40, 0);
		plan_add(PLAN_ALLOC, 16'd40, 0);
		plan_add(PLAN_ALLOC, 16'd40, 0);
		plan_add(PLAN_FREE_LIVE, 16'd0, 2);
		plan_add(PLAN_FREE_LIVE, 16'd0, 1);
		plan_add(PLAN_FREE_TOP, 16'd0, 0);

		// Random phases alternate between filling and draining the region.
		for (int n = 0; n < 1450; n++) begin
			if (n % 100 == 0) alloc_pct = $urandom_range(80, 30);
			if ($urandom_range(99) < alloc_pct) begin
				plan_add(PLAN_ALLOC, draw_size(), 0);
			end else begin
				roll = $urandom_range(99);
				if (roll < 40) begin
					op = PLAN_FREE_TOP;
				end else if (roll < 75) begin
					op = PLAN_FREE_LIVE;
				end else if (roll < 83) begin
					op = PLAN_FREE_STALE;
				end else if (roll < 90) begin
					op = PLAN_FREE_NULL;
				end else begin
					op = PLAN_FREE_JUNK;
				end
				plan_add(op, REQ_W'($urandom), $urandom);
			end
		end
		total = request_plan.size();

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (accepted_cnt != total || pending_replies.size() != 0) @(negedge clk);
		repeat (600) @(negedge clk);
		if (err_cnt == 0 && pending_replies.size() == 0) begin
			$display("lifo_allocator_deferred_free_test: clean");
		end else begin
			$display("lifo_allocator_deferred_free_test: errors");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("lifo_allocator_deferred_free_test: errors");
		$finish;
	end

endmodule
